[sv/hsl_to_rgb_percent_unit_macros.svh]
// assertion helpers for the hsl to rgb unit
`ifndef HSL_TO_RGB_PERCENT_UNIT_MACROS_SVH
`define HSL_TO_RGB_PERCENT_UNIT_MACROS_SVH

// same-cycle implication, off while in reset
`define HSLRGB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hslrgb check failed");

// next-cycle implication, off while in reset
`define HSLRGB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hslrgb check failed");

`endif

[sv/hslrgb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package hslrgb_pkg;

   // field widths
   localparam int unsigned HUE_W = 9;
   localparam int unsigned PCT_W = 7;
   localparam int unsigned CH_W  = 8;

   localparam int unsigned PCT_MAX  = 100;
   localparam int unsigned RAMP_MOD = 200;
   localparam int unsigned CH_SCALE = 255;

   // reciprocal multipliers for constant division
   localparam int unsigned RECIP60  = 1093;   // x/60  = x*RECIP60  >> 16, x < 512
   localparam int unsigned RECIP3   = 43691;  // x/3   = x*RECIP3   >> 17, x < 65536
   localparam int unsigned RECIP200 = 328;    // x/200 = x*RECIP200 >> 16, x < 1000
   localparam int unsigned RECIP100 = 5243;   // x/100 = x*RECIP100 >> 19, x < 43699

   // hue sector codes
   localparam logic [2:0] SEC_RY = 3'd0;
   localparam logic [2:0] SEC_YG = 3'd1;
   localparam logic [2:0] SEC_GC = 3'd2;
   localparam logic [2:0] SEC_CB = 3'd3;
   localparam logic [2:0] SEC_BM = 3'd4;
   localparam logic [2:0] SEC_MR = 3'd5;

   typedef struct packed {
      logic [HUE_W-1:0] hue_deg;
      logic [PCT_W-1:0] sat_pct;
      logic [PCT_W-1:0] light_pct;
   } hslrgb_req_type;

   typedef struct packed {
      logic [CH_W-1:0] red_out;
      logic [CH_W-1:0] green_out;
      logic [CH_W-1:0] blue_out;
   } hslrgb_rsp_type;

   // saturate a percent field at full scale
   function automatic logic [PCT_W-1:0] clamp_pct(input logic [PCT_W-1:0] v);
      clamp_pct = (v > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : v;
   endfunction

   // truncating divide by 100 of a product up to 100*100
   function automatic logic [PCT_W-1:0] div100(input logic [13:0] v);
      logic [26:0] prod;
      prod   = 27'(v) * 27'(RECIP100);
      div100 = prod[25:19];
   endfunction

endpackage
`default_nettype wire

[sv/hslrgb_scale.sv]
`timescale 1ns / 1ps
`default_nettype none
module hslrgb_scale
   import hslrgb_pkg::*;
(
   input  wire logic [PCT_W-1:0] pct,
   output logic      [CH_W-1:0]  level
);

   logic [14:0] times255;
   logic [27:0] prod;

   // pct * 255 / 100, truncated
   assign times255 = {pct, 8'b0} - 15'(pct);
   assign prod     = 28'(times255) * 28'(RECIP100);
   assign level    = prod[26:19];

endmodule
`default_nettype wire

[sv/hsl_to_rgb_percent_unit.sv]
// an accepted request word passes the registered stages 1 through 6 to its response word
// throughput: one word per cycle; a stall on the response side holds the run of full
//    stages next to the output, and stages behind an empty one still advance and fill
// the multiply/shift chain per stage sets the clock; stage 2 chains two multipliers
// reset (synchronous, active high) clears all stage valid bits; data is not reset
`timescale 1ns / 1ps
`default_nettype none
`include "hsl_to_rgb_percent_unit_macros.svh"
module hsl_to_rgb_percent_unit
   import hslrgb_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire hslrgb_req_type req_word,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output hslrgb_rsp_type      rsp_word
);

   // stage valid bits and advance enables
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic en1, en2, en3, en4, en5, en6;

   assign en6 = !v6_ff || !rsp_stall;
   assign en5 = !v5_ff || en6;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_stall = !en1;
   assign rsp_valid = v6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
      end
   end

   // stage 1: sector and hue ramp numerator, clamp percents
   logic [19:0]      hue_q_prod;
   logic [3:0]       hue_q;
   logic [2:0]       sector_in;
   logic [11:0]      hue_x5;
   logic [27:0]      ramp_prod;
   logic [9:0]       ramp_in;
   logic [2:0]       sector1_ff;
   logic [PCT_W-1:0] sat1_ff, lig1_ff;
   logic [9:0]       ramp1_ff;

   assign hue_q_prod = 20'(req_word.hue_deg) * 20'(RECIP60);
   assign hue_q      = hue_q_prod[19:16];
   assign sector_in  = (hue_q >= 4'd6) ? 3'(hue_q - 4'd6) : hue_q[2:0];
   assign hue_x5     = {1'b0, req_word.hue_deg, 2'b0} + 12'(req_word.hue_deg);
   assign ramp_prod  = 28'(hue_x5) * 28'(RECIP3);
   assign ramp_in    = ramp_prod[26:17];

   always_ff @(posedge clock) begin
      if (en1) begin
         sector1_ff <= sector_in;
         sat1_ff    <= clamp_pct(req_word.sat_pct);
         lig1_ff    <= clamp_pct(req_word.light_pct);
         ramp1_ff   <= ramp_in;
      end
   end

   // stage 2: ramp mod 200 into a weight, chroma numerator
   logic [18:0]      ramp_q_prod;
   logic [2:0]       ramp_q;
   logic [9:0]       ramp_rem;
   logic [7:0]       rdist;
   logic [PCT_W-1:0] wt_in;
   logic [7:0]       twol_in;
   logic [7:0]       ldist;
   logic [PCT_W-1:0] span;
   logic [13:0]      cprod_in;
   logic [2:0]       sector2_ff;
   logic [7:0]       twol2_ff;
   logic [PCT_W-1:0] wt2_ff;
   logic [13:0]      cprod2_ff;

   assign ramp_q_prod = 19'(ramp1_ff) * 19'(RECIP200);
   assign ramp_q      = ramp_q_prod[18:16];
   assign ramp_rem    = ramp1_ff - 10'(10'(ramp_q) * 10'(RAMP_MOD));
   assign rdist       = (ramp_rem[7:0] >= 8'(PCT_MAX)) ? ramp_rem[7:0] - 8'(PCT_MAX)
                                                       : 8'(PCT_MAX) - ramp_rem[7:0];
   assign wt_in       = PCT_W'(PCT_MAX) - rdist[6:0];
   assign twol_in     = {lig1_ff, 1'b0};
   assign ldist       = (twol_in >= 8'(PCT_MAX)) ? twol_in - 8'(PCT_MAX)
                                                 : 8'(PCT_MAX) - twol_in;
   assign span        = PCT_W'(PCT_MAX) - ldist[6:0];
   assign cprod_in    = 14'(span) * 14'(sat1_ff);

   always_ff @(posedge clock) begin
      if (en2) begin
         sector2_ff <= sector1_ff;
         twol2_ff   <= twol_in;
         wt2_ff     <= wt_in;
         cprod2_ff  <= cprod_in;
      end
   end

   // stage 3: chroma
   logic [2:0]       sector3_ff;
   logic [7:0]       twol3_ff;
   logic [PCT_W-1:0] wt3_ff;
   logic [PCT_W-1:0] chroma3_ff;

   always_ff @(posedge clock) begin
      if (en3) begin
         sector3_ff <= sector2_ff;
         twol3_ff   <= twol2_ff;
         wt3_ff     <= wt2_ff;
         chroma3_ff <= div100(cprod2_ff);
      end
   end

   // stage 4: offset and secondary numerator
   logic [7:0]       m_diff;
   logic [2:0]       sector4_ff;
   logic [PCT_W-1:0] chroma4_ff;
   logic [PCT_W-1:0] m4_ff;
   logic [13:0]      xprod4_ff;

   assign m_diff = twol3_ff - {1'b0, chroma3_ff};

   always_ff @(posedge clock) begin
      if (en4) begin
         sector4_ff <= sector3_ff;
         chroma4_ff <= chroma3_ff;
         m4_ff      <= m_diff[7:1];
         xprod4_ff  <= 14'(chroma3_ff) * 14'(wt3_ff);
      end
   end

   // stage 5: sector mux into percent channels
   logic [PCT_W-1:0] x_val, hi_val, mid_val;
   logic [PCT_W-1:0] red_in, green_in, blue_in;
   logic [PCT_W-1:0] red5_ff, green5_ff, blue5_ff;

   assign x_val   = div100(xprod4_ff);
   assign hi_val  = chroma4_ff + m4_ff;
   assign mid_val = x_val + m4_ff;

   always_comb begin
      case (sector4_ff)
         SEC_RY: begin
            red_in = hi_val;  green_in = mid_val; blue_in = m4_ff;
         end
         SEC_YG: begin
            red_in = mid_val; green_in = hi_val;  blue_in = m4_ff;
         end
         SEC_GC: begin
            red_in = m4_ff;   green_in = hi_val;  blue_in = mid_val;
         end
         SEC_CB: begin
            red_in = m4_ff;   green_in = mid_val; blue_in = hi_val;
         end
         SEC_BM: begin
            red_in = mid_val; green_in = m4_ff;   blue_in = hi_val;
         end
         default: begin
            red_in = hi_val;  green_in = m4_ff;   blue_in = mid_val;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en5) begin
         red5_ff   <= red_in;
         green5_ff <= green_in;
         blue5_ff  <= blue_in;
      end
   end

   // stage 6: scale to 8-bit levels, output register
   hslrgb_rsp_type rsp_in;
   hslrgb_rsp_type rsp_ff;

   hslrgb_scale u_scale_red   (.pct(red5_ff),   .level(rsp_in.red_out));
   hslrgb_scale u_scale_green (.pct(green5_ff), .level(rsp_in.green_out));
   hslrgb_scale u_scale_blue  (.pct(blue5_ff),  .level(rsp_in.blue_out));

   always_ff @(posedge clock) begin
      if (en6) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_word = rsp_ff;

   // checks
   `HSLRGB_ASSERT_NOW(a_stall_only_when_full, clock, reset,
      req_stall, rsp_stall && v1_ff && v2_ff && v3_ff && v4_ff && v5_ff && v6_ff)
   `HSLRGB_ASSERT_NOW(a_channels_in_range, clock, reset,
      v5_ff, red5_ff <= 7'd100 && green5_ff <= 7'd100 && blue5_ff <= 7'd100)
   `HSLRGB_ASSERT_NOW(a_offset_in_range, clock, reset,
      v4_ff, m4_ff <= 7'd100 && chroma4_ff <= 7'd100)
   `HSLRGB_ASSERT_NEXT(a_held_word_kept, clock, reset,
      v6_ff && rsp_stall && v5_ff,
      v5_ff && $stable(red5_ff) && $stable(green5_ff) && $stable(blue5_ff))

endmodule
`default_nettype wire

[tb/hsl_to_rgb_percent_unit_tb.sv]
`timescale 1ns / 1ps
module hsl_to_rgb_percent_unit_tb;
   import hslrgb_pkg::*;

   localparam int unsigned NUM_DIRECTED = 22;
   localparam int unsigned NUM_RANDOM   = 1300;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned IDLE_LIMIT   = 2000;

   localparam logic TYPED   = 1'b1;
   localparam logic PREDICT = 1'b0;

   typedef struct packed {
      hslrgb_req_type px;
      logic           typed;
      hslrgb_rsp_type rgb;
   } table_row_type;

   // hand-picked pixels: extremes, every hue sector, wrap of hue, clamped percents
   localparam table_row_type STIMULUS_TABLE [NUM_DIRECTED] = '{
      {9'd0,   7'd0,   7'd0,   TYPED,   8'd0,   8'd0,   8'd0},
      {9'd0,   7'd100, 7'd100, TYPED,   8'd255, 8'd255, 8'd255},
      {9'd0,   7'd100, 7'd50,  TYPED,   8'd255, 8'd0,   8'd0},
      {9'd120, 7'd100, 7'd50,  TYPED,   8'd0,   8'd255, 8'd0},
      {9'd240, 7'd100, 7'd50,  TYPED,   8'd0,   8'd0,   8'd255},
      {9'd360, 7'd100, 7'd50,  TYPED,   8'd255, 8'd0,   8'd0},
      {9'd60,  7'd100, 7'd50,  PREDICT, 8'd0,   8'd0,   8'd0},
      {9'd90,  7'd50,  7'd60,  PREDICT, 8'd0,   8'd0,   8'd0},
      {9'd150, 7'd101, 7'd101, PREDICT, 8'd0,   8'd0,   8'd0},
      {9'd180, 7'd100, 7'd50,  PREDICT, 8'd0,   8'd0,   8'd0},
      {9'd200, 7'd80,  7'd127, PREDICT, 8'd0,   8'd0,   8'd0},
      {9'd270, 7'd1,   7'd99,  PREDICT, 8'd0,   8'd0,   8'd0},
      {9'd300, 7'd100, 7'd50,  PREDICT, 8'd0,   8'd0,   8'd0},
      {9'd330, 7'd100, 7'd25,  PREDICT, 8'd0,   8'd0,   8'd0},
      {9'd359, 7'd100, 7'd50,  PREDICT, 8'd0,   8'd0,   8'd0},
      {9'd30,  7'd75,  7'd40,  PREDICT, 8'd0,   8'd0,   8'd0},
      {9'd45,  7'd100, 7'd0,   PREDICT, 8'd0,   8'd0,   8'd0},
      {9'd361, 7'd100, 7'd50,  PREDICT, 8'd0,   8'd0,   8'd0},
      {9'd420, 7'd100, 7'd50,  PREDICT, 8'd0,   8'd0,   8'd0},
      {9'd511, 7'd127, 7'd127, PREDICT, 8'd0,   8'd0,   8'd0},
      {9'd0,   7'd127, 7'd50,  PREDICT, 8'd0,   8'd0,   8'd0},
      {9'd256, 7'd64,  7'd64,  PREDICT, 8'd0,   8'd0,   8'd0}
   };

   logic           clock     = 1'b0;
   logic           reset     = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_stall;
   hslrgb_req_type req_word  = '0;
   logic           rsp_valid;
   logic           rsp_stall = 1'b0;
   hslrgb_rsp_type rsp_word;

   hslrgb_rsp_type rgb_pending[$];
   int unsigned    mismatch_count = 0;
   int unsigned    idle_cycles    = 0;
   int unsigned    stall_left     = 0;
   logic           calm           = 1'b0;

   always #2 clock = ~clock;

   hsl_to_rgb_percent_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // expected color of one pixel
   function automatic hslrgb_rsp_type convert_pixel(input hslrgb_req_type px);
      int unsigned    hue, sat, lig, twol, ldist, chroma, base, ramp, rdist, second;
      int unsigned    hi, mid, r, g, b;
      logic [2:0]     sector;
      hslrgb_rsp_type rgb;
      hue  = px.hue_deg;
      sat  = (px.sat_pct > PCT_MAX) ? PCT_MAX : px.sat_pct;
      lig  = (px.light_pct > PCT_MAX) ? PCT_MAX : px.light_pct;
      sector = 3'((hue / 60) % 6);
      twol   = 2 * lig;
      ldist  = (twol >= 100) ? twol - 100 : 100 - twol;
      chroma = (100 - ldist) * sat / 100;
      base   = (twol - chroma) >> 1;
      ramp   = (hue * 100 / 60) % RAMP_MOD;
      rdist  = (ramp >= 100) ? ramp - 100 : 100 - ramp;
      second = chroma * (100 - rdist) / 100;
      hi     = chroma + base;
      mid    = second + base;
      case (sector)
         SEC_RY: begin r = hi;   g = mid;  b = base; end
         SEC_YG: begin r = mid;  g = hi;   b = base; end
         SEC_GC: begin r = base; g = hi;   b = mid;  end
         SEC_CB: begin r = base; g = mid;  b = hi;   end
         SEC_BM: begin r = mid;  g = base; b = hi;   end
         default: begin r = hi;  g = base; b = mid;  end
      endcase
      rgb.red_out   = CH_W'(r * CH_SCALE / 100);
      rgb.green_out = CH_W'(g * CH_SCALE / 100);
      rgb.blue_out  = CH_W'(b * CH_SCALE / 100);
      return rgb;
   endfunction

   // mostly in-range pixels, some with hue and percents anywhere in their widths
   function automatic hslrgb_req_type random_pixel();
      hslrgb_req_type px;
      px.hue_deg   = ($urandom_range(0, 9) < 7) ? HUE_W'($urandom_range(0, 360))
                                               : HUE_W'($urandom_range(0, 511));
      px.sat_pct   = ($urandom_range(0, 9) < 8) ? PCT_W'($urandom_range(0, 100))
                                               : PCT_W'($urandom_range(0, 127));
      px.light_pct = ($urandom_range(0, 9) < 8) ? PCT_W'($urandom_range(0, 100))
                                               : PCT_W'($urandom_range(0, 127));
      return px;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int unsigned gap_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      else if (pick < 85) return $urandom_range(1, 3);
      else if (pick < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   task automatic check_channel(input string name, input logic [CH_W-1:0] want,
                                input logic [CH_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // request side: table first, then random pixels
   initial begin
      int unsigned    gap;
      hslrgb_req_type px;
      hslrgb_rsp_type rgb_exp;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (int n = 0; n < NUM_DIRECTED + NUM_RANDOM; n++) begin
         if (n < NUM_DIRECTED) begin
            px      = STIMULUS_TABLE[n].px;
            rgb_exp = STIMULUS_TABLE[n].typed ? STIMULUS_TABLE[n].rgb : convert_pixel(px);
         end else begin
            px      = random_pixel();
            rgb_exp = convert_pixel(px);
         end
         // a stretch at full rate on both sides
         calm <= (n >= 500 && n < 700);
         gap = (n >= 500 && n < 700) ? 0 : gap_length();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_word  <= px;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         rgb_pending.push_back(rgb_exp);
      end
      req_valid <= 1'b0;
      calm      <= 1'b0;
      // drain, then watch a while for stray words
      while (rgb_pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // response side: check each word, random stall
   always @(posedge clock) begin : rsp_side
      hslrgb_rsp_type rgb_exp;
      logic           stall_next;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rgb_pending.size() == 0) begin
            $display("%0t: unexpected response word, expected none, actual %h",
                     $time, rsp_word);
            mismatch_count++;
         end else begin
            rgb_exp = rgb_pending.pop_front();
            check_channel("red", rgb_exp.red_out, rsp_word.red_out);
            check_channel("green", rgb_exp.green_out, rsp_word.green_out);
            check_channel("blue", rgb_exp.blue_out, rsp_word.blue_out);
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         stall_next = 1'b1;
      end else begin
         stall_next = 1'b0;
         if (!calm && $urandom_range(0, 3) == 0) stall_left = gap_length();
      end
      rsp_stall <= stall_next;
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
